/* sv/gbr_pkg.sv */
`timescale 1ns / 1ps

package gbr_pkg;

  // Build defaults for the top level parameters
  localparam int KSIZE_DEF     = 5;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int CHANNELS_DEF  = 3;

  // Field and register widths
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 13;
  localparam int SAMPLE_W  = 8;
  localparam int COEFF_W   = 16;
  localparam int CIDX_W    = 7;
  localparam int PROD_W    = COEFF_W + SAMPLE_W;
  localparam int FRAC_W    = 16;
  localparam int PADDR_W   = 3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

  // Register index taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Item kinds; the unused code behaves as a drain step
  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_DRAIN = 2'd2
  } gbr_action_t;

  // Coefficient load travelling down the pipe
  typedef struct packed {
    logic               en;
    logic [CIDX_W-1:0]  idx;
    logic [COEFF_W-1:0] value;
  } gbr_load_t;

  // Result bookkeeping travelling down the pipe
  typedef struct packed {
    logic                res;
    logic                conv;
    logic                last;
    logic [SAMPLE_W-1:0] pass;
  } gbr_res_t;

endpackage

/* sv/gaussian_blur_rgb_stream.sv */
`timescale 1ns / 1ps

// Streaming KSIZE x KSIZE blur over interleaved channel bytes in raster order.
// Every item (pixel byte, coefficient load or drain step) is taken in one cycle
// whenever in_ready is high, and in_ready stays high while out_ready keeps up;
// a stalled output holds the pipe after one result waits in a skid register.
// After the item that completes its window, a result passes through the line
// bank read, the window shift, the tap multipliers, the row sums and the final
// sum and saturation; a stall holds it in place. Results lag the input by
// KSIZE/2 rows plus KSIZE/2 pixels; drain items flush the frame tail.
// Coefficients (unsigned Q0.16) are loaded through the stream and take effect
// for items that follow the load. Writing image_width (0x0) or image_height
// (0x4) restarts the frame; do so only with the pipe empty.
module gaussian_blur_rgb_stream #(
  parameter int KSIZE     = gbr_pkg::KSIZE_DEF,
  parameter int MAX_WIDTH = gbr_pkg::MAX_WIDTH_DEF,
  parameter int CHANNELS  = gbr_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_action,
  input  logic [gbr_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [gbr_pkg::CIDX_W-1:0]   in_coeff_index,
  input  logic [gbr_pkg::COEFF_W-1:0]  in_coeff_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gbr_pkg::SAMPLE_W-1:0] out_sample,
  output logic                         out_frame_last
);
  import gbr_pkg::*;

  localparam int CENTER = KSIZE / 2;
  localparam int DEPTH  = MAX_WIDTH * CHANNELS;
  localparam int BYTE_W = $clog2(DEPTH);
  localparam int RB_W   = BYTE_W + 1;
  localparam int POS_W  = RB_W + HEIGHT_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW_W   = COL_W + 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LINE_W = $clog2(KSIZE);
  localparam int ACC_W  = PROD_W + 2 * $clog2(KSIZE);

  // Configuration
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic                cfg_wr;

  // Frame positions
  logic [POS_W-1:0]    in_pos_r, in_pos_nxt;
  logic [BYTE_W-1:0]   in_byte_r, in_byte_nxt;
  logic [LINE_W-1:0]   in_line_r, in_line_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [HEIGHT_W-1:0] out_row_r, out_row_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [CH_W-1:0]     out_ch_r, out_ch_nxt;
  logic [LINE_W-1:0]   out_line_r, out_line_nxt;

  logic [EW_W-1:0]     eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [RB_W-1:0]     rowbytes;
  logic [POS_W-1:0]    frame;
  logic [POS_W-1:0]    lag;

  logic en, acc, is_load, is_pix, emit, emit_pix, emit_drn, conv0, last0, frame_done;
  logic [POS_W-1:0] p_inc, q_inc;

  // Pipe
  logic                s1_shift_r, s1_res_r, s1_conv_r, s1_last_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [LINE_W-1:0]   s1_inline_r, s1_oline_r;
  gbr_load_t           s1_load_r, s2_load_r;
  gbr_res_t            s2_r, s3_r, s4_r;
  logic [SAMPLE_W-1:0] rd_a [KSIZE];
  logic [SAMPLE_W-1:0] rd_b [KSIZE];
  logic [SAMPLE_W-1:0] col [KSIZE];
  logic [ACC_W-1:0]    sum;
  logic [SAMPLE_W-1:0] res_byte;

  // Output and skid
  logic                out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic [SAMPLE_W-1:0] out_sample_r, out_sample_nxt, skid_sample_r, skid_sample_nxt;
  logic                out_last_r, out_last_nxt, skid_last_r, skid_last_nxt;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
    endcase
  end

  // Clamp the frame geometry
  always_comb begin
    if (width_r == '0) begin
      eff_w = EW_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = EW_W'(width_r);
    end
    eff_h    = (height_r == '0) ? HEIGHT_W'(1) : height_r;
    rowbytes = RB_W'(eff_w * CHANNELS);
    frame    = POS_W'(rowbytes) * POS_W'(eff_h);
    lag      = POS_W'(CENTER) * POS_W'(rowbytes) + POS_W'(CENTER * CHANNELS);
  end

  // Decide what the incoming item does
  assign en       = !skid_valid_r;
  assign in_ready = en;
  assign acc      = in_valid && en;
  assign is_load  = (in_action == ACT_LOAD);
  assign is_pix   = (in_action == ACT_PIXEL) && (in_pos_r < frame);
  assign p_inc    = in_pos_r + POS_W'(1);
  assign q_inc    = out_pos_r + POS_W'(1);
  assign emit_pix = ((p_inc - out_pos_r) > lag) || ((p_inc >= frame) && (out_pos_r < frame));
  assign emit_drn = (in_pos_r >= frame) && (out_pos_r < frame);
  assign emit     = is_load ? 1'b0 : (is_pix ? emit_pix : emit_drn);
  assign frame_done = (q_inc >= frame);
  assign last0    = (q_inc == frame);
  assign conv0    = (32'(out_row_r) >= CENTER) && (32'(out_row_r) + CENTER < 32'(eff_h)) &&
                    (32'(out_col_r) >= CENTER) && (32'(out_col_r) + CENTER < 32'(eff_w));

  // Advance the input and output positions
  always_comb begin
    in_pos_nxt   = in_pos_r;
    in_byte_nxt  = in_byte_r;
    in_line_nxt  = in_line_r;
    out_pos_nxt  = out_pos_r;
    out_row_nxt  = out_row_r;
    out_byte_nxt = out_byte_r;
    out_col_nxt  = out_col_r;
    out_ch_nxt   = out_ch_r;
    out_line_nxt = out_line_r;
    if (acc && is_pix) begin
      in_pos_nxt = p_inc;
      if (RB_W'(in_byte_r) + RB_W'(1) == rowbytes) begin
        in_byte_nxt = '0;
        in_line_nxt = (in_line_r == LINE_W'(KSIZE - 1)) ? '0 : in_line_r + LINE_W'(1);
      end else begin
        in_byte_nxt = in_byte_r + BYTE_W'(1);
      end
    end
    if (acc && emit) begin
      out_pos_nxt = q_inc;
      if (out_ch_r == CH_W'(CHANNELS - 1)) begin
        out_ch_nxt  = '0;
        out_col_nxt = out_col_r + COL_W'(1);
      end else begin
        out_ch_nxt = out_ch_r + CH_W'(1);
      end
      if (RB_W'(out_byte_r) + RB_W'(1) == rowbytes) begin
        out_byte_nxt = '0;
        out_col_nxt  = '0;
        out_ch_nxt   = '0;
        out_row_nxt  = out_row_r + HEIGHT_W'(1);
        out_line_nxt = (out_line_r == LINE_W'(KSIZE - 1)) ? '0 : out_line_r + LINE_W'(1);
      end else begin
        out_byte_nxt = out_byte_r + BYTE_W'(1);
      end
    end
    // Restart at frame end or on a register write
    if ((acc && emit && frame_done) || cfg_wr) begin
      in_pos_nxt   = '0;
      in_byte_nxt  = '0;
      in_line_nxt  = '0;
      out_pos_nxt  = '0;
      out_row_nxt  = '0;
      out_byte_nxt = '0;
      out_col_nxt  = '0;
      out_ch_nxt   = '0;
      out_line_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RST;
      height_r   <= HEIGHT_RST;
      in_pos_r   <= '0;
      in_byte_r  <= '0;
      in_line_r  <= '0;
      out_pos_r  <= '0;
      out_row_r  <= '0;
      out_byte_r <= '0;
      out_col_r  <= '0;
      out_ch_r   <= '0;
      out_line_r <= '0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_WIDTH)) begin
        width_r <= pwdata[WIDTH_W-1:0];
      end
      if (cfg_wr && (paddr[2] == REG_HEIGHT)) begin
        height_r <= pwdata[HEIGHT_W-1:0];
      end
      in_pos_r   <= in_pos_nxt;
      in_byte_r  <= in_byte_nxt;
      in_line_r  <= in_line_nxt;
      out_pos_r  <= out_pos_nxt;
      out_row_r  <= out_row_nxt;
      out_byte_r <= out_byte_nxt;
      out_col_r  <= out_col_nxt;
      out_ch_r   <= out_ch_nxt;
      out_line_r <= out_line_nxt;
    end
  end

  gbr_line_buf #(
    .KSIZE (KSIZE),
    .DEPTH (DEPTH)
  ) u_lines (
    .clk       (clk),
    .en        (en),
    .we        (acc && is_pix),
    .wr_line   (in_line_r),
    .wr_addr   (in_byte_r),
    .wr_data   (in_sample),
    .rd_addr_a (in_byte_r),
    .rd_addr_b (out_byte_r),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_shift_r   <= 1'b0;
      s1_res_r     <= 1'b0;
      s1_load_r.en <= 1'b0;
    end else if (en) begin
      s1_shift_r   <= acc && is_pix;
      s1_res_r     <= acc && emit;
      s1_load_r.en <= acc && is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sample_r     <= in_sample;
      s1_inline_r     <= in_line_r;
      s1_oline_r      <= out_line_r;
      s1_conv_r       <= conv0;
      s1_last_r       <= last0;
      s1_load_r.idx   <= in_coeff_index;
      s1_load_r.value <= in_coeff_value;
    end
  end

  // Pick the column bytes from the banks, oldest line first, with the incoming byte last
  always_comb begin
    int sel;
    sel = 0;
    for (int k = 0; k < KSIZE - 1; k++) begin
      sel = int'(s1_inline_r) + 1 + k;
      if (sel >= KSIZE) begin
        sel = sel - KSIZE;
      end
      col[k] = rd_a[LINE_W'(sel)];
    end
    col[KSIZE-1] = s1_sample_r;
  end

  // Stages 2 to 4 carry the result bookkeeping; stage 2 also carries the coefficient load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.res     <= 1'b0;
      s3_r.res     <= 1'b0;
      s4_r.res     <= 1'b0;
      s2_load_r.en <= 1'b0;
    end else if (en) begin
      s2_r.res     <= s1_res_r;
      s3_r.res     <= s2_r.res;
      s4_r.res     <= s3_r.res;
      s2_load_r.en <= s1_load_r.en;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r.conv       <= s1_conv_r;
      s2_r.last       <= s1_last_r;
      s2_r.pass       <= rd_b[s1_oline_r];
      s3_r.conv       <= s2_r.conv;
      s3_r.last       <= s2_r.last;
      s3_r.pass       <= s2_r.pass;
      s4_r.conv       <= s3_r.conv;
      s4_r.last       <= s3_r.last;
      s4_r.pass       <= s3_r.pass;
      s2_load_r.idx   <= s1_load_r.idx;
      s2_load_r.value <= s1_load_r.value;
    end
  end

  gbr_conv #(
    .KSIZE    (KSIZE),
    .CHANNELS (CHANNELS)
  ) u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .shift (s1_shift_r),
    .col   (col),
    .load  (s2_load_r),
    .sum   (sum)
  );

  // Truncate, saturate and choose the passthrough byte at the border
  always_comb begin
    if (!s4_r.conv) begin
      res_byte = s4_r.pass;
    end else if (|sum[ACC_W-1:FRAC_W+SAMPLE_W]) begin
      res_byte = '1;
    end else begin
      res_byte = sum[FRAC_W+SAMPLE_W-1:FRAC_W];
    end
  end

  // Output register with one skid entry
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_sample_nxt  = out_sample_r;
    out_last_nxt    = out_last_r;
    skid_valid_nxt  = skid_valid_r;
    skid_sample_nxt = skid_sample_r;
    skid_last_nxt   = skid_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_valid_r) begin
      if (!out_valid_r || out_ready) begin
        out_valid_nxt  = 1'b1;
        out_sample_nxt = skid_sample_r;
        out_last_nxt   = skid_last_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (s4_r.res) begin
      if (!out_valid_r || out_ready) begin
        out_valid_nxt  = 1'b1;
        out_sample_nxt = res_byte;
        out_last_nxt   = s4_r.last;
      end else begin
        skid_valid_nxt  = 1'b1;
        skid_sample_nxt = res_byte;
        skid_last_nxt   = s4_r.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r  <= out_sample_nxt;
    out_last_r    <= out_last_nxt;
    skid_sample_r <= skid_sample_nxt;
    skid_last_r   <= skid_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample     = out_sample_r;
  assign out_frame_last = out_last_r;

endmodule

/* sv/gbr_line_buf.sv */
`timescale 1ns / 1ps

module gbr_line_buf #(
  parameter int KSIZE = gbr_pkg::KSIZE_DEF,
  parameter int DEPTH = gbr_pkg::MAX_WIDTH_DEF * gbr_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         we,
  input  logic [$clog2(KSIZE)-1:0]     wr_line,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [gbr_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_b,
  output logic [gbr_pkg::SAMPLE_W-1:0] rd_a [KSIZE],
  output logic [gbr_pkg::SAMPLE_W-1:0] rd_b [KSIZE]
);
  import gbr_pkg::*;

  localparam int LINE_W = $clog2(KSIZE);

  // One bank per image line; port a feeds the window, port b the passthrough byte
  for (genvar i = 0; i < KSIZE; i++) begin : g_bank
    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_a_r;
    logic [SAMPLE_W-1:0] rd_b_r;

    always_ff @(posedge clk) begin
      if (en && we && (wr_line == LINE_W'(i))) begin
        mem[wr_addr] <= wr_data;
      end
      if (en) begin
        rd_a_r <= mem[rd_addr_a];
        rd_b_r <= mem[rd_addr_b];
      end
    end

    assign rd_a[i] = rd_a_r;
    assign rd_b[i] = rd_b_r;
  end

endmodule

/* sv/gbr_conv.sv */
`timescale 1ns / 1ps

module gbr_conv #(
  parameter int KSIZE    = gbr_pkg::KSIZE_DEF,
  parameter int CHANNELS = gbr_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         shift,
  input  logic [gbr_pkg::SAMPLE_W-1:0] col [KSIZE],
  input  gbr_pkg::gbr_load_t           load,
  output logic [gbr_pkg::PROD_W + 2*$clog2(KSIZE)-1:0] sum
);
  import gbr_pkg::*;

  localparam int KK    = KSIZE * KSIZE;
  localparam int TAPS  = (KSIZE - 1) * CHANNELS + 1;
  localparam int RS_W  = PROD_W + $clog2(KSIZE);
  localparam int ACC_W = RS_W + $clog2(KSIZE);

  logic [TAPS-1:0][SAMPLE_W-1:0] win_r [KSIZE];
  logic [COEFF_W-1:0]            coeff_r [KK];
  logic [PROD_W-1:0]             prod_r [KSIZE][KSIZE];
  logic [RS_W-1:0]               rsum_r [KSIZE];

  function automatic logic [RS_W-1:0] row_add(input logic [PROD_W-1:0] p [KSIZE]);
    logic [RS_W-1:0] acc;
    acc = '0;
    for (int d = 0; d < KSIZE; d++) begin
      acc = acc + RS_W'(p[d]);
    end
    return acc;
  endfunction

  // Shift one column of bytes into the window
  always_ff @(posedge clk) begin
    if (en && shift) begin
      for (int k = 0; k < KSIZE; k++) begin
        win_r[k] <= {win_r[k][TAPS-2:0], col[k]};
      end
    end
  end

  // Load coefficients in order with the items around them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < KK; j++) begin
        coeff_r[j] <= '0;
      end
    end else if (en && load.en) begin
      for (int j = 0; j < KK; j++) begin
        if (load.idx == CIDX_W'(j)) begin
          coeff_r[j] <= load.value;
        end
      end
    end
  end

  // Multiply each tap, then sum each row
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < KSIZE; k++) begin
        for (int d = 0; d < KSIZE; d++) begin
          prod_r[k][d] <= PROD_W'(coeff_r[k*KSIZE+d]) *
                          PROD_W'(win_r[k][(KSIZE-1-d)*CHANNELS]);
        end
      end
      for (int k = 0; k < KSIZE; k++) begin
        rsum_r[k] <= row_add(prod_r[k]);
      end
    end
  end

  // Add the row sums
  always_comb begin
    sum = '0;
    for (int k = 0; k < KSIZE; k++) begin
      sum = sum + ACC_W'(rsum_r[k]);
    end
  end

endmodule

/* sv/gbr_checker.sv */
`timescale 1ns / 1ps

module gbr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [gbr_pkg::SAMPLE_W-1:0] out_sample,
  input logic                         out_frame_last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_frame_last))
    else $error("result changed while stalled");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // A taken result frees the input side
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !in_ready |=> in_ready)
    else $error("input stayed stalled after result taken");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output not empty after reset");

endmodule

bind gaussian_blur_rgb_stream gbr_checker u_gbr_checker (.*);
